/* rtl/lsdpt_pkg.sv */
`default_nettype none

package lsdpt_pkg;

	localparam int NUM_DEB = 9;

	// debounced flag lanes
	localparam int SW_WALK_DOWN = 4;
	localparam int SW_WALK_UP   = 5;
	localparam int SW_BACK_UP   = 6;
	localparam int SW_BACK_DOWN = 7;
	localparam int SW_WAVE      = 8;

	// signal byte bits
	localparam int SIG_KNEAD_MAX = 0;
	localparam int SIG_KNEAD_MED = 1;
	localparam int SIG_KNEAD_MIN = 2;
	localparam int SIG_SHOULDER  = 4;
	localparam int SIG_BACK_3D   = 5;
	localparam int SIG_FRONT_3D  = 6;

	localparam logic CMD_TICK       = 1'b0;
	localparam logic CMD_BACK_PULSE = 1'b1;

	localparam logic REG_WALK_TOP = 1'b0;
	localparam logic REG_BACK_MAX = 1'b1;

	localparam logic [15:0] BACK_MAX_RESET = 16'd1000;

	localparam logic [1:0] ZONE_MIDDLE = 2'd0;
	localparam logic [1:0] ZONE_BOTTOM = 2'd1;
	localparam logic [1:0] ZONE_TOP    = 2'd2;

	localparam logic [1:0] KNEAD_UNKNOWN = 2'd0;
	localparam logic [1:0] KNEAD_MIN     = 2'd1;
	localparam logic [1:0] KNEAD_MED     = 2'd2;
	localparam logic [1:0] KNEAD_MAX     = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] raw_switch_byte;
		logic [6:0] signal_byte;
		logic       walk_pulse_level;
		logic       wave_level;
		logic       walk_going_up;
		logic       back_going_up;
	} item_t;

	typedef struct packed {
		logic [8:0]  walk_position;
		logic [1:0]  walk_zone;
		logic [15:0] back_location;
		logic [1:0]  knead_width;
		logic        shoulder_flag;
		logic        front_switch_3d;
		logic        back_switch_3d;
		logic        ready_res;
		logic [15:0] walk_up_run;
		logic [15:0] walk_down_run;
	} track_res_t;

endpackage

`default_nettype wire

/* rtl/limit_switch_debounce_position_tracker.sv */
`default_nettype none

// channel   direction  signals                                    contents
// s_*       in         s_tvalid s_tready s_tdata[23:0] s_tuser    tick or back pulse item
// m_*       out        m_tvalid m_tready m_tdata[79:0]            one result per item
// cfg_*     in         cfg_valid cfg_ready cfg_addr cfg_data      register writes
//
// one item per clock unless m_tready stalls; items pass the input register, then m_tdata
// the state update and result for an item happen in the cycle it leaves the input register
// a stalled output holds one result while the input register holds one more item
// reset clears all tracking state; back_max_position resets to 1000, walk_top_position to 0
// cfg_ready is always high

module limit_switch_debounce_position_tracker import lsdpt_pkg::*; #(
	parameter int DEBOUNCE_SAMPLES = 2,
	parameter int WALK_RAW_LIMIT   = 2000,
	parameter int READY_TICKS      = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raw_switch_byte[7:0], signal_byte[14:8], walk_pulse_level[15], wave_level[16],
	// walk_going_up[17], back_going_up[18], zero[23:19]
	input  wire logic [23:0] s_tdata,
	// cmd
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// switch_flags[8:0], walk_position[17:9], walk_zone[19:18], back_location[35:20],
	// knead_width[37:36], shoulder_flag[38], front_switch_3d[39], back_switch_3d[40],
	// ready_res[41], walk_up_run[57:42], walk_down_run[73:58], zero[79:74]
	output logic      [79:0] m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_data
);

	item_t              item_s1;
	logic               valid_s1;
	logic               adv;
	logic [8:0]         walk_top_q;
	logic [15:0]        back_max_q;
	logic [NUM_DEB-1:0] flags_nxt;
	track_res_t         res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_top_q <= '0;
			back_max_q <= BACK_MAX_RESET;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_WALK_TOP: walk_top_q <= cfg_data[8:0];
				REG_BACK_MAX: back_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd              <= s_tuser;
			item_s1.raw_switch_byte  <= s_tdata[7:0];
			item_s1.signal_byte      <= s_tdata[14:8];
			item_s1.walk_pulse_level <= s_tdata[15];
			item_s1.wave_level       <= s_tdata[16];
			item_s1.walk_going_up    <= s_tdata[17];
			item_s1.back_going_up    <= s_tdata[18];
		end
	end

	logic deb_en;
	assign deb_en = adv && item_s1.cmd == CMD_TICK;

	// switches are active low on the shift register
	lsdpt_debounce #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
	) u_deb (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (deb_en),
		.levels   ({item_s1.wave_level, ~item_s1.raw_switch_byte}),
		.flags_nxt(flags_nxt)
	);

	lsdpt_track #(
		.WALK_RAW_LIMIT(WALK_RAW_LIMIT),
		.READY_TICKS   (READY_TICKS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.item     (item_s1),
		.flags_nxt(flags_nxt),
		.walk_top (walk_top_q),
		.back_max (back_max_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_tdata <= {6'd0, res.walk_down_run, res.walk_up_run, res.ready_res,
				res.back_switch_3d, res.front_switch_3d, res.shoulder_flag,
				res.knead_width, res.back_location, res.walk_zone,
				res.walk_position, flags_nxt};
	end

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken with both stages full");
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("processed item produced no result");
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

/* rtl/lsdpt_debounce.sv */
`default_nettype none

module lsdpt_debounce import lsdpt_pkg::*; #(
	parameter int DEBOUNCE_SAMPLES = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [NUM_DEB-1:0] levels,
	output logic      [NUM_DEB-1:0] flags_nxt
);

	localparam int CW = $clog2(DEBOUNCE_SAMPLES + 1);
	localparam logic [CW:0]   LIM   = (CW + 1)'(DEBOUNCE_SAMPLES);
	localparam logic [CW-1:0] LIM_N = CW'(DEBOUNCE_SAMPLES);

	logic [CW-1:0] hi_q [NUM_DEB];
	logic [CW-1:0] lo_q [NUM_DEB];
	logic [CW-1:0] hi_n [NUM_DEB];
	logic [CW-1:0] lo_n [NUM_DEB];
	logic [CW:0]   hi_inc [NUM_DEB];
	logic [CW:0]   lo_inc [NUM_DEB];
	logic [NUM_DEB-1:0] flag_q;

	always_comb begin
		for (int k = 0; k < NUM_DEB; k++) begin
			hi_inc[k]    = (CW + 1)'(hi_q[k]) + (CW + 1)'(1);
			lo_inc[k]    = (CW + 1)'(lo_q[k]) + (CW + 1)'(1);
			hi_n[k]      = hi_q[k];
			lo_n[k]      = lo_q[k];
			flags_nxt[k] = flag_q[k];
			if (en) begin
				if (levels[k]) begin
					lo_n[k] = '0;
					if (hi_inc[k] >= LIM) begin
						hi_n[k]      = LIM_N;
						flags_nxt[k] = 1'b1;
					end else begin
						hi_n[k] = hi_inc[k][CW-1:0];
					end
				end else begin
					hi_n[k] = '0;
					if (lo_inc[k] >= LIM) begin
						lo_n[k]      = LIM_N;
						flags_nxt[k] = 1'b0;
					end else begin
						lo_n[k] = lo_inc[k][CW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_DEB; k++) begin
				hi_q[k] <= '0;
				lo_q[k] <= '0;
			end
			flag_q <= '0;
		end else if (en) begin
			for (int k = 0; k < NUM_DEB; k++) begin
				hi_q[k] <= hi_n[k];
				lo_q[k] <= lo_n[k];
			end
			flag_q <= flags_nxt;
		end
	end

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(flag_q))
		else $error("debounced flags changed without a sample");

	for (genvar g = 0; g < NUM_DEB; g++) begin : g_chk
		a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
			!(hi_q[g] != '0 && lo_q[g] != '0))
			else $error("high and low runs both active");
		a_flag_rise: assert property (@(posedge clk) disable iff (!arst_n)
			$rose(flag_q[g]) |-> $past(en) && $past(levels[g]))
			else $error("flag set without a high sample");
	end

endmodule

`default_nettype wire

/* rtl/lsdpt_track.sv */
`default_nettype none

module lsdpt_track import lsdpt_pkg::*; #(
	parameter int WALK_RAW_LIMIT = 2000,
	parameter int READY_TICKS    = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire item_t              item,
	input  wire logic [NUM_DEB-1:0] flags_nxt,
	input  wire logic [8:0]         walk_top,
	input  wire logic [15:0]        back_max,
	output track_res_t              res
);

	localparam int TW = $clog2(READY_TICKS + 1);
	localparam logic [10:0]   RAW_LIMIT = 11'(WALK_RAW_LIMIT);
	localparam logic [TW-1:0] TICKS     = TW'(READY_TICKS);

	logic [10:0]   raw_q, raw_n;
	logic          prev_q, prev_n;
	logic [15:0]   up_q, up_n;
	logic [15:0]   dn_q, dn_n;
	logic [15:0]   bp_q, bp_n;
	logic [1:0]    knead_q, knead_n;
	logic          shoulder_q, shoulder_n;
	logic          front_q, front_n;
	logic          back3d_q, back3d_n;
	logic [TW-1:0] tc_q, tc_n;
	logic          ready_q, ready_n;

	always_comb begin
		raw_n      = raw_q;
		prev_n     = prev_q;
		up_n       = up_q;
		dn_n       = dn_q;
		bp_n       = bp_q;
		knead_n    = knead_q;
		shoulder_n = shoulder_q;
		front_n    = front_q;
		back3d_n   = back3d_q;
		tc_n       = tc_q;
		ready_n    = ready_q;
		if (en) begin
			if (item.cmd == CMD_BACK_PULSE) begin
				// back pulse sees the flags as they stand
				if (!item.back_going_up) begin
					if (bp_q < back_max)
						bp_n = bp_q + 16'd1;
					if (flags_nxt[SW_BACK_DOWN])
						bp_n = back_max;
				end else begin
					if (bp_q != 16'd0)
						bp_n = bp_q - 16'd1;
					if (flags_nxt[SW_BACK_UP])
						bp_n = '0;
				end
			end else begin
				if (tc_q < TICKS)
					tc_n = tc_q + TW'(1);
				if (tc_n >= TICKS)
					ready_n = 1'b1;
				if (item.signal_byte[SIG_KNEAD_MAX])
					knead_n = KNEAD_MAX;
				else if (item.signal_byte[SIG_KNEAD_MED])
					knead_n = KNEAD_MED;
				else if (item.signal_byte[SIG_KNEAD_MIN])
					knead_n = KNEAD_MIN;
				shoulder_n = item.signal_byte[SIG_SHOULDER];
				front_n    = item.signal_byte[SIG_FRONT_3D];
				back3d_n   = item.signal_byte[SIG_BACK_3D];
				// walk limits use the flags just updated by this tick
				if (item.walk_pulse_level != prev_q) begin
					if (!item.walk_going_up) begin
						up_n = '0;
						dn_n = dn_q + 16'd1;
						if (raw_q != 11'd0)
							raw_n = raw_q - 11'd1;
						if (flags_nxt[SW_WALK_DOWN])
							raw_n = '0;
					end else begin
						up_n = up_q + 16'd1;
						dn_n = '0;
						if (raw_q < RAW_LIMIT)
							raw_n = raw_q + 11'd1;
						if (flags_nxt[SW_WALK_UP])
							raw_n = {walk_top, 2'b00};
					end
				end
				prev_n = item.walk_pulse_level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q      <= '0;
			prev_q     <= 1'b0;
			up_q       <= '0;
			dn_q       <= '0;
			bp_q       <= '0;
			knead_q    <= KNEAD_UNKNOWN;
			shoulder_q <= 1'b0;
			front_q    <= 1'b0;
			back3d_q   <= 1'b0;
			tc_q       <= '0;
			ready_q    <= 1'b0;
		end else begin
			raw_q      <= raw_n;
			prev_q     <= prev_n;
			up_q       <= up_n;
			dn_q       <= dn_n;
			bp_q       <= bp_n;
			knead_q    <= knead_n;
			shoulder_q <= shoulder_n;
			front_q    <= front_n;
			back3d_q   <= back3d_n;
			tc_q       <= tc_n;
			ready_q    <= ready_n;
		end
	end

	always_comb begin
		res.walk_position   = raw_n[10:2];
		if (flags_nxt[SW_WALK_DOWN])
			res.walk_zone = ZONE_BOTTOM;
		else if (flags_nxt[SW_WALK_UP])
			res.walk_zone = ZONE_TOP;
		else
			res.walk_zone = ZONE_MIDDLE;
		res.back_location   = bp_n;
		res.knead_width     = knead_n;
		res.shoulder_flag   = shoulder_n;
		res.front_switch_3d = front_n;
		res.back_switch_3d  = back3d_n;
		res.ready_res       = ready_n;
		res.walk_up_run     = up_n;
		res.walk_down_run   = dn_n;
	end

	a_back_keeps_walk: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.cmd == CMD_BACK_PULSE |=> $stable(raw_q) && $stable(up_q) && $stable(dn_q))
		else $error("back pulse disturbed walk state");
	a_tick_keeps_back: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.cmd == CMD_TICK |=> $stable(bp_q))
		else $error("tick disturbed back position");
	a_ready_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("ready flag dropped");
	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_q != 16'd0 && dn_q != 16'd0))
		else $error("up and down runs both nonzero");

endmodule

`default_nettype wire

/* verif/limit_tracker_checker.sv */
`timescale 1ns / 1ps

module limit_tracker_checker import lsdpt_pkg::*; #(
	parameter int DEBOUNCE_SAMPLES = 2,
	parameter int WALK_RAW_LIMIT   = 2000,
	parameter int READY_TICKS      = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// raw_switch_byte, signal_byte, walk_pulse_level, wave_level, walk_going_up,
	// back_going_up, zero
	input  logic [23:0] s_tdata,
	// cmd
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// switch_flags, walk_position, walk_zone, back_location, knead_width, shoulder_flag,
	// front_switch_3d, back_switch_3d, ready_res, walk_up_run, walk_down_run, zero
	input  logic [79:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          compared
);

	// m_tdata layout, highest field first
	typedef struct packed {
		logic [5:0]  zero_fill;
		logic [15:0] walk_down_run;
		logic [15:0] walk_up_run;
		logic        ready_res;
		logic        back_switch_3d;
		logic        front_switch_3d;
		logic        shoulder_flag;
		logic [1:0]  knead_width;
		logic [15:0] back_location;
		logic [1:0]  walk_zone;
		logic [8:0]  walk_position;
		logic [8:0]  switch_flags;
	} report_t;

	logic [8:0]         walk_top;
	logic [15:0]        back_max;
	logic [1:0]         high_run [NUM_DEB];
	logic [1:0]         low_run [NUM_DEB];
	logic [NUM_DEB-1:0] deb_flags;
	logic [10:0]        walk_raw;
	logic               walk_prev;
	logic [15:0]        up_edges;
	logic [15:0]        down_edges;
	logic [15:0]        back_pos;
	logic [1:0]         knead;
	logic               shoulder;
	logic               front_3d;
	logic               back_3d;
	logic [2:0]         ticks;
	logic               is_ready;
	report_t            predicted_reports[$];

	function automatic void sample_lane(int k, logic level);
		int run;
		if (level) begin
			low_run[k] = 2'd0;
			run = int'(high_run[k]) + 1;
			if (run >= DEBOUNCE_SAMPLES) begin
				high_run[k] = 2'(DEBOUNCE_SAMPLES);
				deb_flags[k] = 1'b1;
			end else begin
				high_run[k] = 2'(run);
			end
		end else begin
			high_run[k] = 2'd0;
			run = int'(low_run[k]) + 1;
			if (run >= DEBOUNCE_SAMPLES) begin
				low_run[k] = 2'(DEBOUNCE_SAMPLES);
				deb_flags[k] = 1'b0;
			end else begin
				low_run[k] = 2'(run);
			end
		end
	endfunction

	function automatic void take_tick(logic [23:0] d);
		logic [7:0] sw;
		logic [6:0] sig;
		logic       lvl;
		sw = ~d[7:0];
		sig = d[14:8];
		lvl = d[15];
		if (ticks < READY_TICKS)
			ticks = ticks + 3'd1;
		if (ticks >= READY_TICKS)
			is_ready = 1'b1;
		// widest knead bit wins
		if (sig[SIG_KNEAD_MIN])
			knead = KNEAD_MIN;
		if (sig[SIG_KNEAD_MED])
			knead = KNEAD_MED;
		if (sig[SIG_KNEAD_MAX])
			knead = KNEAD_MAX;
		shoulder = sig[SIG_SHOULDER];
		front_3d = sig[SIG_FRONT_3D];
		back_3d = sig[SIG_BACK_3D];
		for (int k = 0; k < 8; k++)
			sample_lane(k, sw[k]);
		sample_lane(SW_WAVE, d[16]);
		// limit flags are the freshly debounced ones
		if (lvl != walk_prev) begin
			if (!d[17]) begin
				up_edges = 16'd0;
				down_edges = down_edges + 16'd1;
				if (walk_raw != 11'd0)
					walk_raw = walk_raw - 11'd1;
				if (deb_flags[SW_WALK_DOWN])
					walk_raw = 11'd0;
			end else begin
				up_edges = up_edges + 16'd1;
				down_edges = 16'd0;
				if (walk_raw < WALK_RAW_LIMIT)
					walk_raw = walk_raw + 11'd1;
				if (deb_flags[SW_WALK_UP])
					walk_raw = {walk_top, 2'b00};
			end
		end
		walk_prev = lvl;
	endfunction

	function automatic void take_back_pulse(logic going_up);
		if (!going_up) begin
			if (back_pos < back_max)
				back_pos = back_pos + 16'd1;
			if (deb_flags[SW_BACK_DOWN])
				back_pos = back_max;
		end else begin
			if (back_pos != 16'd0)
				back_pos = back_pos - 16'd1;
			if (deb_flags[SW_BACK_UP])
				back_pos = 16'd0;
		end
	endfunction

	function automatic report_t tracker_report();
		report_t r;
		r = '0;
		r.switch_flags = deb_flags;
		r.walk_position = walk_raw[10:2];
		if (deb_flags[SW_WALK_DOWN])
			r.walk_zone = ZONE_BOTTOM;
		else if (deb_flags[SW_WALK_UP])
			r.walk_zone = ZONE_TOP;
		else
			r.walk_zone = ZONE_MIDDLE;
		r.back_location = back_pos;
		r.knead_width = knead;
		r.shoulder_flag = shoulder;
		r.front_switch_3d = front_3d;
		r.back_switch_3d = back_3d;
		r.ready_res = is_ready;
		r.walk_up_run = up_edges;
		r.walk_down_run = down_edges;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void compare_report(report_t got);
		report_t want;
		if (predicted_reports.size() == 0) begin
			$error("result transaction with no prediction waiting");
			fail_count++;
			return;
		end
		want = predicted_reports.pop_front();
		compared++;
		check_field("switch_flags", want.switch_flags, got.switch_flags);
		check_field("walk_position", want.walk_position, got.walk_position);
		check_field("walk_zone", want.walk_zone, got.walk_zone);
		check_field("back_location", want.back_location, got.back_location);
		check_field("knead_width", want.knead_width, got.knead_width);
		check_field("shoulder_flag", want.shoulder_flag, got.shoulder_flag);
		check_field("front_switch_3d", want.front_switch_3d, got.front_switch_3d);
		check_field("back_switch_3d", want.back_switch_3d, got.back_switch_3d);
		check_field("ready_res", want.ready_res, got.ready_res);
		check_field("walk_up_run", want.walk_up_run, got.walk_up_run);
		check_field("walk_down_run", want.walk_down_run, got.walk_down_run);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_top = 9'd0;
			back_max = BACK_MAX_RESET;
			for (int k = 0; k < NUM_DEB; k++) begin
				high_run[k] = 2'd0;
				low_run[k] = 2'd0;
			end
			deb_flags = '0;
			walk_raw = 11'd0;
			walk_prev = 1'b0;
			up_edges = 16'd0;
			down_edges = 16'd0;
			back_pos = 16'd0;
			knead = KNEAD_UNKNOWN;
			shoulder = 1'b0;
			front_3d = 1'b0;
			back_3d = 1'b0;
			ticks = 3'd0;
			is_ready = 1'b0;
			predicted_reports.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_addr == REG_WALK_TOP)
					walk_top = cfg_data[8:0];
				else
					back_max = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_BACK_PULSE)
					take_back_pulse(s_tdata[18]);
				else
					take_tick(s_tdata);
				predicted_reports.push_back(tracker_report());
			end
			if (m_tvalid && m_tready)
				compare_report(m_tdata);
			pending = predicted_reports.size();
		end
	end

endmodule

/* verif/limit_switch_debounce_position_tracker_test.sv */
`timescale 1ns / 1ps

module limit_switch_debounce_position_tracker_test;
	import lsdpt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_addr;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int compared;
	int tick_total;
	int pulse_total;
	int setting_total;
	int send_burst;
	int take_burst;

	// slowly changing switch picture for the random part
	logic [7:0] held_raw;
	logic       held_wave;
	logic       walk_lvl;
	logic       walk_dir;
	logic       back_dir;

	limit_switch_debounce_position_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	limit_tracker_checker tracker_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending),
		.compared  (compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle cycles before the next transaction, with runs of back-to-back ones
	function automatic int pick_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic send_item(logic cmd, logic [23:0] payload);
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= payload;
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_TICK)
			tick_total++;
		else
			pulse_total++;
	endtask

	task automatic send_tick(logic [7:0] raw, logic [6:0] sig, logic lvl, logic wave,
			logic going_up);
		send_item(CMD_TICK, {5'd0, 1'($urandom_range(0, 1)), going_up, wave, lvl, sig, raw});
	endtask

	// tick fields ride along with random content
	task automatic send_pulse(logic going_up);
		logic [23:0] noise;
		noise = 24'($urandom);
		send_item(CMD_BACK_PULSE, {5'd0, going_up, noise[17:0]});
	endtask

	task automatic random_tick();
		logic [7:0] raw;
		logic [6:0] sig;
		logic       wave;
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 3))
				0: held_raw = ~(8'($urandom) & 8'($urandom) & 8'($urandom));
				1: held_raw = 8'hFF;
				2: held_raw = 8'($urandom);
				default: held_raw = ~(8'd1 << $urandom_range(SW_WALK_DOWN, SW_BACK_DOWN));
			endcase
		end
		if ($urandom_range(0, 99) < 15)
			held_wave = ~held_wave;
		raw = held_raw;
		wave = held_wave;
		// single-sample bounce
		if ($urandom_range(0, 99) < 10)
			raw = raw ^ (8'd1 << $urandom_range(0, 7));
		if ($urandom_range(0, 99) < 5)
			wave = ~wave;
		if ($urandom_range(0, 99) < 70)
			walk_lvl = ~walk_lvl;
		if ($urandom_range(0, 99) < 8)
			walk_dir = ~walk_dir;
		sig = 7'($urandom);
		if ($urandom_range(0, 2) == 0)
			sig[2:0] = 3'b000;
		send_tick(raw, sig, walk_lvl, wave, walk_dir);
	endtask

	task automatic write_regs(logic [15:0] top_val, logic [15:0] max_val);
		cfg_valid <= 1'b1;
		cfg_addr <= REG_WALK_TOP;
		cfg_data <= top_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_addr <= REG_BACK_MAX;
		cfg_data <= max_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		setting_total++;
	endtask

	// wait for every predicted result, then let the pipeline empty
	task automatic settle(int extra);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap(take_burst);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [15:0] top_val;
		logic [15:0] max_val;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_addr <= REG_WALK_TOP;
		cfg_data <= '0;
		held_raw = 8'hFF;
		held_wave = 1'b0;
		walk_lvl = 1'b0;
		walk_dir = 1'b1;
		back_dir = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		send_pulse(1'b1);
		send_pulse(1'b0);
		send_tick(8'hFF, 7'h00, 1'b0, 1'b0, 1'b0);
		send_tick(8'h00, 7'h04, 1'b1, 1'b1, 1'b0);
		// all limits settle, up edge loads the walk top
		send_tick(8'h00, 7'h06, 1'b0, 1'b1, 1'b1);
		send_tick(8'h00, 7'h07, 1'b1, 1'b1, 1'b0);
		send_pulse(1'b0);
		send_pulse(1'b1);
		// no knead bit: width kept
		send_tick(8'hFF, 7'h00, 1'b0, 1'b0, 1'b1);
		send_tick(8'hFF, 7'h70, 1'b1, 1'b0, 1'b1);
		send_tick(8'hFF, 7'h7F, 1'b0, 1'b1, 1'b1);
		send_tick(8'hFF, 7'h10, 1'b0, 1'b0, 1'b1);
		send_tick(8'h7F, 7'h20, 1'b1, 1'b0, 1'b0);
		send_pulse(1'b0);
		send_pulse(1'b0);
		send_tick(8'h7F, 7'h40, 1'b0, 1'b0, 1'b0);
		send_pulse(1'b0);
		send_pulse(1'b1);
		send_tick(8'hAA, 7'h03, 1'b1, 1'b1, 1'b1);
		send_tick(8'h55, 7'h05, 1'b0, 1'b0, 1'b0);
		send_tick(8'hBF, 7'h08, 1'b1, 1'b1, 1'b1);
		send_tick(8'hBF, 7'h02, 1'b0, 1'b1, 1'b0);
		send_pulse(1'b1);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin top_val = 16'd500; max_val = 16'd0; end
				1: begin top_val = 16'd511; max_val = 16'hFFFF; end
				2: begin top_val = {7'($urandom), 9'($urandom_range(0, 511))}; max_val = 16'd30; end
				3: begin top_val = 16'd500; max_val = 16'd5; end
				4: begin top_val = 16'd0; max_val = 16'd1; end
				5: begin
					top_val = 16'($urandom_range(0, 511));
					max_val = 16'($urandom_range(1, 60));
				end
				default: begin top_val = 16'd500; max_val = 16'd1000; end
			endcase
			settle(4);
			write_regs(top_val, max_val);
			repeat (175) begin
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 99) < 15)
						back_dir = ~back_dir;
					send_pulse(back_dir);
				end else begin
					random_tick();
				end
			end
		end

		settle(8);
		$display("sent %0d sample ticks and %0d back pulses across %0d register settings",
			tick_total, pulse_total, setting_total);
		$display("%0d results compared field by field, %0d mismatches", compared, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* limit_switch_debounce_position_tracker.f */
rtl/lsdpt_pkg.sv
rtl/lsdpt_debounce.sv
rtl/lsdpt_track.sv
rtl/limit_switch_debounce_position_tracker.sv
verif/limit_tracker_checker.sv
verif/limit_switch_debounce_position_tracker_test.sv
